[rtl/irsd_pkg.sv]
// Shared constants, GF(256) arithmetic and state type for the interleaved RS decoder.
package irsd_pkg;

  localparam int MAX_DEPTH       = 4;
  localparam int CODEWORD_LENGTH = 255;
  localparam int CORRECTABLE     = 16;
  localparam int NSYN            = 2 * CORRECTABLE;
  localparam int FRAME           = MAX_DEPTH * CODEWORD_LENGTH;
  localparam int AW              = $clog2(FRAME);
  localparam int S_TDATA_W       = 24;
  localparam int M_TDATA_W       = 24;
  localparam int CFG_W           = 3;
  localparam logic [8:0] FIELD_POLY = 9'h187;
  localparam logic [7:0] ROOT_STEP  = 8'd11;
  localparam logic [7:0] FIRST_ROOT = 8'd112;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD, ST_SYN_START, ST_SYN, ST_SYN_TAIL, ST_BM_D, ST_BM_C, ST_BM_U,
    ST_CH_START, ST_CH, ST_CH_CHK, ST_OM, ST_FN_EVAL, ST_FN_MUL1, ST_FN_MUL2, ST_FN_WR,
    ST_EMIT
  } state_t;

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] x;
    logic [7:0] y;
    logic [7:0] acc;
    acc = '0;
    x = {1'b0, a};
    y = b;
    for (int i = 0; i < 8; i++) begin
      if (y[0]) acc ^= x[7:0];
      y = y >> 1;
      x = x << 1;
      if (x[8]) x ^= FIELD_POLY;
    end
    return acc;
  endfunction

  function automatic logic [7:0] gpow(input logic [7:0] a, input logic [7:0] e);
    logic [7:0] r;
    logic [7:0] x;
    r = 8'h01;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (e[i]) r = gmul(r, x);
      x = gmul(x, x);
    end
    return r;
  endfunction

  function automatic logic [255:0][7:0] gen_inv();
    logic [255:0][7:0] t;
    for (int v = 0; v < 256; v++) t[v] = (v == 0) ? 8'h00 : gpow(8'(v), 8'd254);
    return t;
  endfunction

  localparam logic [7:0] BETA    = gpow(8'h02, ROOT_STEP);
  localparam logic [7:0] BINV    = gpow(BETA, 8'd254);
  localparam logic [7:0] FC_STEP = gpow(BINV, FIRST_ROOT - 8'd1);
  localparam logic [255:0][7:0] INV_TABLE = gen_inv();

  function automatic logic [NSYN-1:0][7:0] gen_syn_roots();
    logic [NSYN-1:0][7:0] t;
    logic [7:0] z;
    z = gpow(BETA, FIRST_ROOT);
    for (int k = 0; k < NSYN; k++) begin
      t[k] = z;
      z = gmul(z, BETA);
    end
    return t;
  endfunction

  function automatic logic [CORRECTABLE:0][7:0] gen_chien();
    logic [CORRECTABLE:0][7:0] t;
    for (int j = 0; j <= CORRECTABLE; j++) t[j] = gpow(BINV, 8'(j));
    return t;
  endfunction

  localparam logic [NSYN-1:0][7:0]      SYN_ROOT  = gen_syn_roots();
  localparam logic [CORRECTABLE:0][7:0] CHIEN_MUL = gen_chien();

endpackage

[rtl/irsd_cell.sv]
// One GF(256) cell: multiply-accumulate register with an XOR chain to its neighbor.
module irsd_cell (
  input  logic       clk,
  input  logic       load,
  input  logic [7:0] load_val,
  input  logic       step,
  input  logic [7:0] mul,
  input  logic [7:0] add_in,
  input  logic [7:0] chain_in,
  output logic [7:0] value,
  output logic [7:0] chain_out
);
  import irsd_pkg::*;

  always_ff @(posedge clk) begin
    if (load) begin
      value <= load_val;
    end else if (step) begin
      value <= gmul(value, mul) ^ add_in;
    end
  end

  assign chain_out = chain_in ^ value;
endmodule

[rtl/interleaved_rs_255_223_decoder.sv]
// Top level: frame buffer, syndrome/Chien cell rows, Berlekamp-Massey and Forney sequencer.
//
// channel   | dir | signals                         | item
// s_axis    | in  | tvalid tready tdata tuser tlast | write or read request
// m_axis    | out | tvalid tready tdata tuser tlast | status or read result
// cfg       | in  | cfg_we cfg_wdata                | interleave depth
//
// Write: stored when accepted. Read: registered memory read, then the result register.
// Decode per codeword: syndromes, Berlekamp-Massey, Chien search, omega, then a Forney
// step per corrected symbol; zero syndromes or a failed Chien check end it early.
// rst is synchronous; the frame buffer is not cleared.
// Input is held off while decoding and while a result waits unaccepted.
module interleaved_rs_255_223_decoder (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // byte_index[9:0], data_byte[17:10], zero pad
  input  logic [irsd_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // kind
  input  logic                             s_axis_tuser,
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // byte_value[7:0], codeword_number[9:8], corrections[14:10], codeword_failed[15],
  // total_corrections[22:16], packet_failed[23]
  output logic [irsd_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // result_kind
  output logic                             m_axis_tuser,
  output logic                             m_axis_tlast,
  input  logic                             cfg_we,
  input  logic [irsd_pkg::CFG_W-1:0]       cfg_wdata
);
  import irsd_pkg::*;

  state_t state, state_next;

  logic [7:0]    mem [FRAME];
  logic [7:0]    rdata;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_raddr, mem_waddr;
  logic [7:0]    mem_wdata;

  logic [CFG_W-1:0] depth_reg, depth;
  logic [1:0]    cw;
  logic [AW-1:0] saddr, fix_addr;
  logic [7:0]    sidx;
  logic          syn_pv, rd_oob;

  logic [7:0] syn [NSYN];
  logic [7:0] lam [CORRECTABLE+1];
  logic [7:0] prev [CORRECTABLE+1];
  logic [5:0] len, m_gap;
  logic [4:0] n;
  logic [7:0] pd, d, coef, d_calc;
  logic [7:0] lam_upd [CORRECTABLE+1];

  logic [7:0] ch_val [CORRECTABLE+1];
  logic [7:0] ch_chain [CORRECTABLE+2];
  logic [7:0] p, r, q;
  logic [4:0] count;
  logic [7:0] pos [CORRECTABLE];
  logic [7:0] rts [CORRECTABLE];
  logic [7:0] fcs [CORRECTABLE];

  logic [4:0] om_j, kidx, fidx;
  logic [7:0] omega [NSYN];
  logic [7:0] nv, dv, t1, e, lder_k;
  logic       fail, pfail, syn_any;
  logic [6:0] total;

  logic       s_acc, out_free, syn_step, ch_load, ch_step, syn_load;
  logic [4:0] res;

  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign res      = fail ? 5'd0 : count;

  // frame buffer
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= mem[mem_raddr];
  end

  // syndrome cell row
  assign syn_load = (state == ST_SYN_START);
  assign syn_step = (state == ST_SYN || state == ST_SYN_TAIL) && syn_pv;
  for (genvar k = 0; k < NSYN; k++) begin : g_syn
    irsd_cell u_cell (
      .clk(clk), .load(syn_load), .load_val(8'h00), .step(syn_step),
      .mul(SYN_ROOT[k]), .add_in(rdata), .chain_in(8'h00),
      .value(syn[k]), .chain_out()
    );
  end

  always_comb begin
    syn_any = 1'b0;
    for (int k = 0; k < NSYN; k++) syn_any |= (syn[k] != 8'h00);
  end

  // Chien cell row
  assign ch_load = (state == ST_CH_START);
  assign ch_step = (state == ST_CH);
  assign ch_chain[0] = 8'h00;
  for (genvar j = 0; j <= CORRECTABLE; j++) begin : g_ch
    irsd_cell u_cell (
      .clk(clk), .load(ch_load), .load_val(lam[j]), .step(ch_step),
      .mul(CHIEN_MUL[j]), .add_in(8'h00), .chain_in(ch_chain[j]),
      .value(ch_val[j]), .chain_out(ch_chain[j+1])
    );
  end

  // BM discrepancy and locator update
  always_comb begin
    logic [4:0] si;
    logic [5:0] diff;
    d_calc = 8'h00;
    for (int i = 0; i <= CORRECTABLE; i++) begin
      si = n - 5'(i);
      if (6'(i) <= len && 5'(i) <= n) d_calc ^= gmul(syn[si], lam[i]);
    end
    for (int i = 0; i <= CORRECTABLE; i++) begin
      diff = 6'(i) - m_gap;
      lam_upd[i] = (6'(i) >= m_gap) ? (lam[i] ^ gmul(coef, prev[diff[4:0]])) : lam[i];
    end
  end

  always_comb begin
    lder_k = 8'h00;
    if (kidx < 5'(CORRECTABLE) && !kidx[0]) lder_k = lam[kidx + 5'd1];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (s_acc) begin
                      if (s_axis_tuser) state_next = ST_RD;
                      else if (s_axis_tlast) state_next = ST_SYN_START;
                    end
      ST_RD:        state_next = ST_IDLE;
      ST_SYN_START: state_next = ST_SYN;
      ST_SYN:       if (sidx == 8'd0) state_next = ST_SYN_TAIL;
      // last syndrome step lands at this edge; zero check waits for ST_BM_D
      ST_SYN_TAIL:  state_next = ST_BM_D;
      ST_BM_D:      state_next = syn_any ? ST_BM_C : ST_EMIT;
      ST_BM_C:      if (d_calc == 8'h00 && d == 8'h00) begin
                      state_next = (n == 5'd31) ? ST_CH_START : ST_BM_D;
                    end else begin
                      state_next = ST_BM_U;
                    end
      ST_BM_U:      state_next = (n == 5'd31) ? ST_CH_START : ST_BM_D;
      ST_CH_START:  state_next = ST_CH;
      ST_CH:        if (p == 8'd254) state_next = ST_CH_CHK;
      ST_CH_CHK:    state_next = (count > 5'(CORRECTABLE) || 6'(count) != len) ?
                                 ST_EMIT : ST_OM;
      ST_OM:        if (om_j == 5'd0) state_next = ST_FN_EVAL;
      ST_FN_EVAL:   if (kidx == 5'd0) state_next = ST_FN_MUL1;
      ST_FN_MUL1:   state_next = ST_FN_MUL2;
      ST_FN_MUL2:   state_next = ST_FN_WR;
      ST_FN_WR:     state_next = (fidx + 5'd1 == count) ? ST_EMIT : ST_FN_EVAL;
      ST_EMIT:      if (out_free) begin
                      state_next = (3'(cw) + 3'd1 == depth) ? ST_IDLE : ST_SYN_START;
                    end
      default:      state_next = ST_IDLE;
    endcase
  end

  // memory port and handshake controls
  always_comb begin
    s_axis_tready = (state == ST_IDLE) && out_free;
    mem_re    = 1'b0;
    mem_raddr = saddr;
    mem_we    = 1'b0;
    mem_waddr = s_axis_tdata[AW-1:0];
    mem_wdata = s_axis_tdata[17:10];
    case (state)
      ST_IDLE: begin
        mem_re    = s_acc && s_axis_tuser;
        mem_raddr = s_axis_tdata[AW-1:0];
        mem_we    = s_acc && !s_axis_tuser && (s_axis_tdata[9:0] < 10'(FRAME));
      end
      ST_SYN: mem_re = 1'b1;
      ST_FN_MUL2: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(pos[fidx[3:0]]) * AW'(depth) + AW'(cw);
      end
      ST_FN_WR: begin
        mem_we    = (dv != 8'h00);
        mem_waddr = fix_addr;
        mem_wdata = rdata ^ e;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      depth_reg     <= CFG_W'(MAX_DEPTH);
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) depth_reg <= cfg_wdata;
      if ((state == ST_RD) || (state == ST_EMIT && out_free)) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        rd_oob <= (s_axis_tdata[9:0] >= 10'(FRAME));
        cw     <= 2'd0;
        total  <= 7'd0;
        pfail  <= 1'b0;
        if (depth_reg == '0) depth <= CFG_W'(1);
        else if (depth_reg > CFG_W'(MAX_DEPTH)) depth <= CFG_W'(MAX_DEPTH);
        else depth <= depth_reg;
      end
      ST_SYN_START: begin
        saddr  <= AW'(CODEWORD_LENGTH - 1) * AW'(depth) + AW'(cw);
        sidx   <= 8'(CODEWORD_LENGTH - 1);
        syn_pv <= 1'b0;
        count  <= 5'd0;
        fail   <= 1'b0;
        for (int i = 0; i <= CORRECTABLE; i++) begin
          lam[i]  <= (i == 0) ? 8'h01 : 8'h00;
          prev[i] <= (i == 0) ? 8'h01 : 8'h00;
        end
        len   <= 6'd0;
        pd    <= 8'h01;
        m_gap <= 6'd1;
        n     <= 5'd0;
        d     <= 8'h00;
      end
      ST_SYN: begin
        syn_pv <= 1'b1;
        saddr  <= saddr - AW'(depth);
        sidx   <= sidx - 8'd1;
      end
      ST_BM_D: d <= d_calc;
      ST_BM_C: begin
        if (d == 8'h00) begin
          m_gap <= m_gap + 6'd1;
          n     <= n + 5'd1;
        end else begin
          coef <= gmul(d, INV_TABLE[pd]);
        end
      end
      ST_BM_U: begin
        for (int i = 0; i <= CORRECTABLE; i++) lam[i] <= lam_upd[i];
        if ({3'b0, n} >= {1'b0, len, 1'b0}) begin
          for (int i = 0; i <= CORRECTABLE; i++) prev[i] <= lam[i];
          pd    <= d;
          len   <= {1'b0, n} + 6'd1 - len;
          m_gap <= 6'd1;
        end else begin
          m_gap <= m_gap + 6'd1;
        end
        n <= n + 5'd1;
        d <= 8'h00;
      end
      ST_CH_START: begin
        p <= 8'd0;
        r <= 8'h01;
        q <= 8'h01;
      end
      ST_CH: begin
        if (ch_chain[CORRECTABLE+1] == 8'h00) begin
          if (count < 5'(CORRECTABLE)) begin
            pos[count[3:0]] <= p;
            rts[count[3:0]] <= r;
            fcs[count[3:0]] <= q;
          end
          if (count <= 5'(CORRECTABLE)) count <= count + 5'd1;
        end
        p <= p + 8'd1;
        r <= gmul(r, BINV);
        q <= gmul(q, FC_STEP);
      end
      ST_CH_CHK: begin
        fail <= (count > 5'(CORRECTABLE) || 6'(count) != len);
        om_j <= 5'(CORRECTABLE);
        for (int k = 0; k < NSYN; k++) omega[k] <= 8'h00;
      end
      ST_OM: begin
        for (int k = 0; k < NSYN; k++) begin
          omega[k] <= ((k > 0) ? omega[(k > 0) ? k - 1 : 0] : 8'h00) ^
                      gmul(syn[k], lam[om_j]);
        end
        om_j <= om_j - 5'd1;
        fidx <= 5'd0;
        kidx <= 5'(NSYN - 1);
        nv   <= 8'h00;
        dv   <= 8'h00;
      end
      ST_FN_EVAL: begin
        nv   <= gmul(nv, rts[fidx[3:0]]) ^ omega[kidx];
        dv   <= gmul(dv, rts[fidx[3:0]]) ^ lder_k;
        kidx <= kidx - 5'd1;
      end
      ST_FN_MUL1: t1 <= gmul(nv, fcs[fidx[3:0]]);
      ST_FN_MUL2: begin
        e        <= gmul(t1, INV_TABLE[dv]);
        fix_addr <= mem_raddr;
      end
      ST_FN_WR: begin
        fidx <= fidx + 5'd1;
        kidx <= 5'(NSYN - 1);
        nv   <= 8'h00;
        dv   <= 8'h00;
      end
      ST_EMIT: begin
        if (out_free) begin
          total <= total + 7'(res);
          pfail <= pfail | fail;
          cw    <= cw + 2'd1;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == ST_RD) begin
      m_axis_tuser <= 1'b1;
      m_axis_tlast <= 1'b0;
      m_axis_tdata <= {16'h0000, rd_oob ? 8'h00 : rdata};
    end else if (state == ST_EMIT && out_free) begin
      m_axis_tuser <= 1'b0;
      m_axis_tlast <= (3'(cw) + 3'd1 == depth);
      m_axis_tdata <= {pfail | fail, total + 7'(res), fail, res, cw, 8'h00};
    end
  end
endmodule

[rtl/irsd_checker.sv]
// Port-level checks on the interleaved RS decoder, bound to the top level.
module irsd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [irsd_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser,
  input logic                           m_axis_tlast
);
  import irsd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_read: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[23:8] == 16'h0000 && !m_axis_tlast)
    else $error("read result carries status fields");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[14:10] <= 5'(CORRECTABLE) &&
    m_axis_tdata[7:0] == 8'h00 && (!m_axis_tdata[15] || m_axis_tdata[14:10] == 5'd0))
    else $error("bad codeword status");

  a_pfail: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser && m_axis_tdata[15] |-> m_axis_tdata[23])
    else $error("codeword failure not reflected in frame status");
endmodule

bind interleaved_rs_255_223_decoder irsd_checker u_irsd_checker (
  .clk(clk), .rst(rst), .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
);
